// ----- rtl/lfpd_pkg.sv -----
// ============================================================================
// Line follower PID drive package
// Shared payload types, register indexes and fixed constants.
// ============================================================================
package lfpd_pkg;

  // Input item: two signed errors, both regulated toward zero.
  typedef struct packed {
    logic signed [15:0] line_error;
    logic signed [15:0] speed_error;
  } lfpd_in_t;

  // Result item: servo and motor compare values.
  typedef struct packed {
    logic [11:0] servo_pwm;
    logic [12:0] left_motor_pwm;
    logic [12:0] right_motor_pwm;
  } lfpd_out_t;

  localparam int unsigned CFG_INDEX_W = 4;
  localparam int unsigned GAIN_W      = 32;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [GAIN_W-1:0]      gain_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_STEER_KP = 4'd0;
  localparam cfg_index_t REG_STEER_KI = 4'd1;
  localparam cfg_index_t REG_STEER_KD = 4'd2;
  localparam cfg_index_t REG_DIFF_KP  = 4'd3;
  localparam cfg_index_t REG_DIFF_KI  = 4'd4;
  localparam cfg_index_t REG_DIFF_KD  = 4'd5;
  localparam cfg_index_t REG_SPEED_KP = 4'd6;
  localparam cfg_index_t REG_SPEED_KD = 4'd7;

  // Gain reset values, unsigned Q16.16.
  localparam gain_t RST_STEER_KP = 32'd2293760;
  localparam gain_t RST_STEER_KI = 32'd655;
  localparam gain_t RST_STEER_KD = 32'd28835840;
  localparam gain_t RST_DIFF_KP  = 32'd15728640;
  localparam gain_t RST_DIFF_KI  = 32'd32768;
  localparam gain_t RST_DIFF_KD  = 32'd294912000;
  localparam gain_t RST_SPEED_KP = 32'd10485760;
  localparam gain_t RST_SPEED_KD = 32'd5898240;

  // Output limits and offsets.
  localparam logic [11:0] SERVO_MIN    = 12'd500;
  localparam logic [11:0] SERVO_MAX    = 12'd2500;
  localparam logic [11:0] SERVO_CENTER = 12'd1580;
  localparam logic [12:0] MOTOR_MAX    = 13'd7200;

endpackage

// ----- rtl/line_follow_pid_drive.sv -----
// ============================================================================
// Line follower PID drive
// One control tick per input transfer: steering servo and two wheel motors.
// ============================================================================
// The block runs one control tick for every input transfer and returns one
// result transfer for it, in order. It accepts a new item in every cycle
// unless a stall fills every stage. Each item passes through an input stage
// that updates the shared saturating integral and the error differences, a
// stage of eight gain multipliers (the widest is 32 x 32 bits), a stage
// that sums the terms of each controller exactly in Q16.16, a stage that
// truncates each sum toward zero, and a stage that adds the servo center,
// mixes speed and differential and clamps into the output register. A
// stalled output holds the pipeline only where it is full, so bubbles close
// up and input stays open while a result waits. Gains are written through
// the configuration port, which is always ready; registers beyond the list
// ignore the write. Gains are read in the multiplier stage, so they must be
// written by the user only while no item is in flight; nothing enforces it.
`default_nettype none

module line_follow_pid_drive
  import lfpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,

  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lfpd_in_t   in_data,

  output logic            out_valid,
  input  wire logic       out_ready,
  output lfpd_out_t       out_data,

  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_index_t cfg_index,
  input  wire gain_t      cfg_data
);

  // Integral saturation bound, plus and minus 2^31-1.
  localparam logic signed [32:0] INTEG_MAX = 33'sd2147483647;
  localparam logic signed [32:0] INTEG_MIN = -33'sd2147483647;
  // Base speed 7200 in Q16.16.
  localparam logic signed [51:0] SPEED_BASE_Q = 52'sd471859200;

  // --------------------------------------------------------------------------
  // Gain registers
  // --------------------------------------------------------------------------
  gain_t steer_kp_r, steer_ki_r, steer_kd_r;
  gain_t diff_kp_r, diff_ki_r, diff_kd_r;
  gain_t speed_kp_r, speed_kd_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_kp_r <= RST_STEER_KP;
      steer_ki_r <= RST_STEER_KI;
      steer_kd_r <= RST_STEER_KD;
      diff_kp_r  <= RST_DIFF_KP;
      diff_ki_r  <= RST_DIFF_KI;
      diff_kd_r  <= RST_DIFF_KD;
      speed_kp_r <= RST_SPEED_KP;
      speed_kd_r <= RST_SPEED_KD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEER_KP: steer_kp_r <= cfg_data;
        REG_STEER_KI: steer_ki_r <= cfg_data;
        REG_STEER_KD: steer_kd_r <= cfg_data;
        REG_DIFF_KP:  diff_kp_r  <= cfg_data;
        REG_DIFF_KI:  diff_ki_r  <= cfg_data;
        REG_DIFF_KD:  diff_kd_r  <= cfg_data;
        REG_SPEED_KP: speed_kp_r <= cfg_data;
        REG_SPEED_KD: speed_kd_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control. A stage loads when it is empty or when the stage
  // after it is moving, so the output stall only backs up through full stages.
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic in_xfer;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: controller state. The integral takes the new line error first
  // and saturates; both PID terms then read the updated value.
  // --------------------------------------------------------------------------
  logic signed [31:0] integ_r;
  logic signed [15:0] last_le_r, last_se_r;
  logic signed [32:0] integ_sum;
  logic signed [31:0] integ_nxt;

  always_comb begin
    integ_sum = 33'(integ_r) + 33'(in_data.line_error);
    if (integ_sum > INTEG_MAX) begin
      integ_nxt = INTEG_MAX[31:0];
    end else if (integ_sum < INTEG_MIN) begin
      integ_nxt = INTEG_MIN[31:0];
    end else begin
      integ_nxt = integ_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r   <= '0;
      last_le_r <= '0;
      last_se_r <= '0;
    end else if (in_xfer) begin
      integ_r   <= integ_nxt;
      last_le_r <= in_data.line_error;
      last_se_r <= in_data.speed_error;
    end
  end

  logic signed [15:0] s1_le_r, s1_se_r;
  logic signed [31:0] s1_integ_r;
  logic signed [16:0] s1_dle_r, s1_dse_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_le_r    <= in_data.line_error;
      s1_se_r    <= in_data.speed_error;
      s1_integ_r <= integ_nxt;
      s1_dle_r   <= 17'(in_data.line_error) - 17'(last_le_r);
      s1_dse_r   <= 17'(in_data.speed_error) - 17'(last_se_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain products, exact in Q16.16. Gains are unsigned, so each one
  // enters the signed multiply with a zero sign bit.
  // --------------------------------------------------------------------------
  logic signed [47:0] s2_steer_p_r, s2_diff_p_r, s2_speed_p_r;
  logic signed [63:0] s2_steer_i_r, s2_diff_i_r;
  logic signed [48:0] s2_steer_d_r, s2_diff_d_r, s2_speed_d_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_steer_p_r <= $signed({1'b0, steer_kp_r}) * s1_le_r;
      s2_steer_i_r <= $signed({1'b0, steer_ki_r}) * s1_integ_r;
      s2_steer_d_r <= $signed({1'b0, steer_kd_r}) * s1_dle_r;
      s2_diff_p_r  <= $signed({1'b0, diff_kp_r}) * s1_le_r;
      s2_diff_i_r  <= $signed({1'b0, diff_ki_r}) * s1_integ_r;
      s2_diff_d_r  <= $signed({1'b0, diff_kd_r}) * s1_dle_r;
      s2_speed_p_r <= $signed({1'b0, speed_kp_r}) * s1_se_r;
      s2_speed_d_r <= $signed({1'b0, speed_kd_r}) * s1_dse_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: exact term sums per controller.
  // --------------------------------------------------------------------------
  logic signed [65:0] s3_steer_sum_r, s3_diff_sum_r;
  logic signed [51:0] s3_speed_sum_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_steer_sum_r <= 66'(s2_steer_p_r) + 66'(s2_steer_i_r) + 66'(s2_steer_d_r);
      s3_diff_sum_r  <= 66'(s2_diff_p_r) + 66'(s2_diff_i_r) + 66'(s2_diff_d_r);
      s3_speed_sum_r <= SPEED_BASE_Q - 52'(s2_speed_p_r) + 52'(s2_speed_d_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: truncation toward zero. The arithmetic shift floors; a negative
  // sum with a nonzero fraction is then moved up by one.
  // --------------------------------------------------------------------------
  logic steer_up, diff_up, speed_up;
  logic signed [49:0] s4_steer_r, s4_diff_r;
  logic signed [35:0] s4_speed_r;

  assign steer_up = s3_steer_sum_r[65] && (s3_steer_sum_r[15:0] != 16'd0);
  assign diff_up  = s3_diff_sum_r[65] && (s3_diff_sum_r[15:0] != 16'd0);
  assign speed_up = s3_speed_sum_r[51] && (s3_speed_sum_r[15:0] != 16'd0);

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_steer_r <= s3_steer_sum_r[65:16] + $signed({49'd0, steer_up});
      s4_diff_r  <= s3_diff_sum_r[65:16] + $signed({49'd0, diff_up});
      s4_speed_r <= s3_speed_sum_r[51:16] + $signed({35'd0, speed_up});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: servo offset, wheel mixing and clamping into the output register.
  // --------------------------------------------------------------------------
  logic signed [50:0] servo_sum, left_sum, right_sum;
  lfpd_out_t          out_nxt;
  lfpd_out_t          out_data_r;

  always_comb begin
    servo_sum = 51'(s4_steer_r) + $signed({39'd0, SERVO_CENTER});
    left_sum  = 51'(s4_speed_r) + 51'(s4_diff_r);
    right_sum = 51'(s4_speed_r) - 51'(s4_diff_r);

    if (servo_sum < $signed({39'd0, SERVO_MIN})) begin
      out_nxt.servo_pwm = SERVO_MIN;
    end else if (servo_sum > $signed({39'd0, SERVO_MAX})) begin
      out_nxt.servo_pwm = SERVO_MAX;
    end else begin
      out_nxt.servo_pwm = servo_sum[11:0];
    end

    if (left_sum[50]) begin
      out_nxt.left_motor_pwm = '0;
    end else if (left_sum > $signed({38'd0, MOTOR_MAX})) begin
      out_nxt.left_motor_pwm = MOTOR_MAX;
    end else begin
      out_nxt.left_motor_pwm = left_sum[12:0];
    end

    if (right_sum[50]) begin
      out_nxt.right_motor_pwm = '0;
    end else if (right_sum > $signed({38'd0, MOTOR_MAX})) begin
      out_nxt.right_motor_pwm = MOTOR_MAX;
    end else begin
      out_nxt.right_motor_pwm = right_sum[12:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/lfpd_checker.sv -----
// ============================================================================
// Line follower PID drive checker
// Port-level assertions, bound to the top level.
// ============================================================================
module lfpd_checker
  import lfpd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input lfpd_out_t  out_data
);

  // A result held back by the consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // The pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // Commands stay inside their clamp ranges.
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.servo_pwm >= SERVO_MIN) && (out_data.servo_pwm <= SERVO_MAX)
                  && (out_data.left_motor_pwm <= MOTOR_MAX)
                  && (out_data.right_motor_pwm <= MOTOR_MAX))
    else $error("command outside its range");

  // An item with room at the output is never refused at the input.
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with an empty output");

endmodule

bind line_follow_pid_drive lfpd_checker u_lfpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- dv/tb_line_follow_pid_drive.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Line follower PID drive testbench
// Drives control ticks through the block under random input gaps and output
// stalls. Expected servo and motor commands are predicted with exact Q16.16
// arithmetic in the testbench and compared field by field, in order.
// ============================================================================
module tb_line_follow_pid_drive;
  import lfpd_pkg::*;

  // Wide signed type for exact term sums. The largest product is a 32-bit gain
  // times a 32-bit integral, and three of them are summed, so 96 bits is plenty.
  typedef logic signed [95:0] wide_t;

  localparam wide_t Q_ONE      = 96'sd65536;
  localparam wide_t INTEG_SAT  = 96'sd2147483647;
  localparam wide_t SERVO_LO   = {84'b0, SERVO_MIN};
  localparam wide_t SERVO_HI   = {84'b0, SERVO_MAX};
  localparam wide_t SERVO_MID  = {84'b0, SERVO_CENTER};
  localparam wide_t MOTOR_TOP  = {83'b0, MOTOR_MAX};
  localparam wide_t MOTOR_ZERO = 96'sd0;

  // Highest index the configuration port can carry; everything above
  // REG_SPEED_KD is an unused register and the write must be dropped.
  localparam cfg_index_t REG_TOP_INDEX = '1;

  // Five pipeline stages, plus a little margin.
  localparam int SETTLE_CYCLES = 8;

  // Generous run limit in ns, well above the slowest correct run, with every
  // tick behind a long input gap and a long output stall.
  localparam int RUN_LIMIT_NS = 25_000_000;

  function automatic wide_t ext_gain(gain_t g);
    return {64'b0, g};
  endfunction

  function automatic wide_t ext_err(logic signed [15:0] v);
    return {{80{v[15]}}, v};
  endfunction

  function automatic wide_t clamp_wide(wide_t v, wide_t lo, wide_t hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the gains and controller state, turns
  // every accepted tick into the expected drive command and checks the
  // commands that come out, oldest first.
  // --------------------------------------------------------------------------
  class pid_drive_scoreboard;
    gain_t     gains [8];
    wide_t     integ;
    wide_t     last_line;
    wide_t     last_speed;
    lfpd_out_t expected_cmds [$];
    int        failures;
    int        checked;

    function new();
      gains[REG_STEER_KP] = RST_STEER_KP;
      gains[REG_STEER_KI] = RST_STEER_KI;
      gains[REG_STEER_KD] = RST_STEER_KD;
      gains[REG_DIFF_KP]  = RST_DIFF_KP;
      gains[REG_DIFF_KI]  = RST_DIFF_KI;
      gains[REG_DIFF_KD]  = RST_DIFF_KD;
      gains[REG_SPEED_KP] = RST_SPEED_KP;
      gains[REG_SPEED_KD] = RST_SPEED_KD;
      integ      = '0;
      last_line  = '0;
      last_speed = '0;
      failures   = 0;
      checked    = 0;
    endfunction

    function void set_gain(cfg_index_t idx, gain_t val);
      if (idx <= REG_SPEED_KD) gains[idx] = val;
    endfunction

    function int pending();
      return expected_cmds.size();
    endfunction

    // Exact positional PID sum, truncated toward zero by signed division.
    function wide_t pid_sum(gain_t kp, gain_t ki, gain_t kd, wide_t e, wide_t acc,
                            wide_t de);
      return (ext_gain(kp) * e + ext_gain(ki) * acc + ext_gain(kd) * de) / Q_ONE;
    endfunction

    function lfpd_out_t drive_cmd(lfpd_in_t tick);
      wide_t     le;
      wide_t     se;
      wide_t     de;
      wide_t     steer;
      wide_t     diff;
      wide_t     speed;
      wide_t     servo;
      wide_t     left;
      wide_t     right;
      lfpd_out_t cmd;
      le = ext_err(tick.line_error);
      se = ext_err(tick.speed_error);

      // The integral takes the new error first and both controllers read it.
      integ = clamp_wide(integ + le, -INTEG_SAT, INTEG_SAT);
      de    = le - last_line;
      steer = pid_sum(gains[REG_STEER_KP], gains[REG_STEER_KI], gains[REG_STEER_KD],
                      le, integ, de);
      diff  = pid_sum(gains[REG_DIFF_KP], gains[REG_DIFF_KI], gains[REG_DIFF_KD],
                      le, integ, de);
      last_line = le;

      // Base speed starts from full scale, which is the motor limit itself.
      speed = (MOTOR_TOP * Q_ONE - ext_gain(gains[REG_SPEED_KP]) * se
               + ext_gain(gains[REG_SPEED_KD]) * (se - last_speed)) / Q_ONE;
      last_speed = se;

      servo = clamp_wide(SERVO_MID + steer, SERVO_LO, SERVO_HI);
      left  = clamp_wide(speed + diff, MOTOR_ZERO, MOTOR_TOP);
      right = clamp_wide(speed - diff, MOTOR_ZERO, MOTOR_TOP);
      cmd.servo_pwm       = servo[11:0];
      cmd.left_motor_pwm  = left[12:0];
      cmd.right_motor_pwm = right[12:0];
      return cmd;
    endfunction

    function void note_tick(lfpd_in_t tick);
      expected_cmds.push_back(drive_cmd(tick));
    endfunction

    function void check_cmd(lfpd_out_t got);
      lfpd_out_t want;
      checked++;
      if (expected_cmds.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: unexpected command servo %0d left %0d right %0d",
                   checked, got.servo_pwm, got.left_motor_pwm, got.right_motor_pwm);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.servo_pwm != want.servo_pwm ||
          got.left_motor_pwm != want.left_motor_pwm ||
          got.right_motor_pwm != want.right_motor_pwm) begin
        failures++;
        if (failures <= 10)
          $display({"result %0d: servo exp %0d got %0d, left exp %0d got %0d, ",
                    "right exp %0d got %0d"},
                   checked, want.servo_pwm, got.servo_pwm, want.left_motor_pwm,
                   got.left_motor_pwm, want.right_motor_pwm, got.right_motor_pwm);
      end
    endfunction

    function void check_leftovers();
      if (expected_cmds.size() > 0) begin
        $display("%0d expected commands never arrived", expected_cmds.size());
        failures += expected_cmds.size();
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  lfpd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  lfpd_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  cfg_index_t cfg_index;
  gain_t     cfg_data;

  pid_drive_scoreboard board;

  // When set, neither side idles: used for back-to-back stretches.
  bit quiet;

  line_follow_pid_drive dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Error values: a mix of full-range words, small and medium magnitudes, and
  // the corner values.
  function automatic logic signed [15:0] rand_err();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom;
      3, 4, 5: v = $signed($urandom_range(0, 128)) - 64;
      6, 7:    v = $signed($urandom_range(0, 4096)) - 2048;
      default: begin
        case ($urandom_range(0, 4))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v[15:0];
  endfunction

  // Gains: mostly moderate values with random fraction bits, sometimes a full
  // random word, zero or all ones.
  function automatic gain_t rand_gain();
    case ($urandom_range(0, 19))
      0:          return '0;
      1:          return '1;
      2, 3, 4:    return gain_t'($urandom);
      default:    return gain_t'($urandom >> $urandom_range(8, 31));
    endcase
  endfunction

  function automatic lfpd_in_t tick_of(logic signed [15:0] le, logic signed [15:0] se);
    lfpd_in_t t;
    t.line_error  = le;
    t.speed_error = se;
    return t;
  endfunction

  // Offers one tick after an optional gap and returns at the edge where the
  // transfer happens. Valid stays high on return, so the caller either sends
  // the next tick right away or lowers it.
  task automatic send_tick(input lfpd_in_t tick);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_tick(tick);
  endtask

  // Stops the input side and waits until every expected command has come
  // back, then lets the pipeline settle. Gains are only touched after this.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write. Valid drops for a cycle afterwards, so back-to-back
  // writes never raise and lower it in the same step.
  task automatic program_gain(input cfg_index_t idx, input gain_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_gain(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: checks every transfer and stalls ready at random.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_valid && out_ready) board.check_cmd(out_data);
      if (quiet) stall_left = 0;
      else if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Hard stop in case the block hangs.
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    board     = new();
    quiet     = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks with the reset gains: zero, the four corner combinations
    // of both errors, sign flips of one step, and a full-swing derivative.
    send_tick(tick_of(16'sd0, 16'sd0));
    send_tick(tick_of(16'sd32767, 16'sd32767));
    send_tick(tick_of(-16'sd32768, -16'sd32768));
    send_tick(tick_of(16'sd32767, -16'sd32768));
    send_tick(tick_of(-16'sd32768, 16'sd32767));
    send_tick(tick_of(16'sd1, -16'sd1));
    send_tick(tick_of(-16'sd1, 16'sd1));
    send_tick(tick_of(16'sd100, -16'sd50));
    send_tick(tick_of(16'sd0, 16'sd0));

    // A write to an unused register index must leave every gain alone.
    drain_results();
    program_gain(REG_TOP_INDEX, '1);
    program_gain(REG_SPEED_KD + 4'd1, '1);
    send_tick(tick_of(-16'sd32768, 16'sd32767));
    send_tick(tick_of(16'sd32767, -16'sd32768));

    // All gains zero: servo sits at center and both motors at full speed.
    drain_results();
    for (int r = REG_STEER_KP; r <= REG_SPEED_KD; r++) program_gain(cfg_index_t'(r), '0);
    send_tick(tick_of(16'sd32767, -16'sd32768));
    send_tick(tick_of(-16'sd32768, 16'sd32767));
    send_tick(tick_of(16'sd0, 16'sd0));

    // All gains at their maximum: the widest products and sums.
    drain_results();
    for (int r = REG_STEER_KP; r <= REG_SPEED_KD; r++) program_gain(cfg_index_t'(r), '1);
    send_tick(tick_of(16'sd32767, 16'sd32767));
    send_tick(tick_of(-16'sd32768, -16'sd32768));
    send_tick(tick_of(16'sd32767, -16'sd32768));
    send_tick(tick_of(16'sd0, 16'sd0));

    // Random phases. Each one rewrites a random subset of the gains and pokes
    // an unused index; every fourth phase runs without idling on either side.
    // Now and then the sender holds off until the pipeline is empty.
    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      quiet = (ph % 4 == 3);
      for (int r = REG_STEER_KP; r <= REG_SPEED_KD; r++)
        if ($urandom_range(0, 1) == 1) program_gain(cfg_index_t'(r), rand_gain());
      program_gain(cfg_index_t'($urandom_range(REG_SPEED_KD + 1, REG_TOP_INDEX)),
                   gain_t'($urandom));
      for (int n = 0; n < 240; n++) begin
        if ($urandom_range(0, 149) == 0) drain_results();
        send_tick(tick_of(rand_err(), rand_err()));
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (20) @(posedge clk);
    board.check_leftovers();
    if (board.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lfpd_pkg.sv
rtl/line_follow_pid_drive.sv
rtl/lfpd_checker.sv
dv/tb_line_follow_pid_drive.sv
